FILE: rtl/core/kmpq_pkg.sv
// shared types, codes and defaults of the keyed min priority queue
package kmpq_pkg;

  localparam int unsigned KmpqCapacity = 64;

  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_SETPRIO = 2'd1;
  localparam logic [1:0] MODE_REMOVE  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_SETPRIO,
    OP_REMOVE,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        prio;
  } cmd_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] prio;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP_RD,
    ST_POP_CHK,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_INS_RD,
    ST_INS_CHK,
    ST_RESP
  } state_e;

endpackage

FILE: rtl/core/keyed_min_priority_queue.sv
// top level of the keyed min priority queue with decrease-key
// search, shift and insert each walk the entry memory one entry at a time
// commands: the back end works on one at a time; a two-beat queue takes more meanwhile
// results are strobed on valid_o for one cycle and cannot be stalled
// reset: asynchronous, active low; clears the count and queue, entry memory is not cleared
module keyed_min_priority_queue import kmpq_pkg::*; #(
  parameter int unsigned CAPACITY = KmpqCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic [31:0]        priority_req_i,
  output logic               valid_o,
  output logic [1:0]         status_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic [6:0]         occupancy_o
);

  // decoded command beat handed from front to back
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  kmpq_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .priority_req_i (priority_req_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // back end keeps the entries sorted by priority, new entries behind their equals
  kmpq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .occupancy_o (occupancy_o)
  );

endmodule

FILE: rtl/core/kmpq_front.sv
// front end: takes command beats, decodes the mode and queues them for the back end
module kmpq_front import kmpq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic [31:0]        priority_req_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  op_e        op_dec;
  logic       pop;

  always_comb begin
    case (mode_i)
      MODE_INSERT:  op_dec = OP_INSERT;
      MODE_SETPRIO: op_dec = OP_SETPRIO;
      MODE_REMOVE:  op_dec = OP_REMOVE;
      default:      op_dec = OP_NOP;
    endcase
  end

  assign busy        = (fill_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{op: op_dec, x: point_x_i, y: point_y_i, prio: priority_req_i};
    end
  end

endmodule

FILE: rtl/core/kmpq_back.sv
// back end: sorted entry memory and the sequencer that searches, shifts and inserts
module kmpq_back import kmpq_pkg::*; #(
  parameter int unsigned CAPACITY = KmpqCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               valid_o,
  output logic [1:0]         status_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic [6:0]         occupancy_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  entry_t mem [CAPACITY];
  entry_t rdata_q;
  entry_t new_entry;

  state_e        state_q, state_d;
  cmd_t          cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] hole_q, hole_d;
  logic [1:0]    status_q, status_d;
  logic [15:0]   ox_q, ox_d;
  logic [15:0]   oy_q, oy_d;

  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  entry_t        wdata;
  logic          key_hit;
  logic          goes_after;
  logic [CW-1:0] hole_m1;

  assign new_entry  = '{x: cmd_q.x, y: cmd_q.y, prio: cmd_q.prio};
  assign key_hit    = (rdata_q.x == cmd_q.x) && (rdata_q.y == cmd_q.y);
  assign hole_m1    = hole_q - CW'(1);
  // equal priorities that sat ahead of the updated entry stay ahead
  assign goes_after = (rdata_q.prio > cmd_q.prio) ||
                      ((rdata_q.prio == cmd_q.prio) && (hole_m1 >= pos_q));

  // next state and working registers
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    hole_d   = hole_q;
    status_d = status_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          status_d = STATUS_OK;
          ox_d     = '0;
          oy_d     = '0;
          idx_d    = '0;
          case (cmd_i.op)
            OP_INSERT, OP_SETPRIO: state_d = ST_SCAN_RD;
            OP_REMOVE: begin
              if (cnt_q == '0) begin
                status_d = STATUS_EMPTY;
                state_d  = ST_RESP;
              end else begin
                state_d = ST_POP_RD;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (idx_q == cnt_q) begin
          if (cmd_q.op == OP_SETPRIO) begin
            state_d = ST_RESP;
          end else if (cnt_q >= CapCount) begin
            status_d = STATUS_FULL;
            state_d  = ST_RESP;
          end else begin
            pos_d   = cnt_q;
            hole_d  = cnt_q;
            state_d = ST_INS_RD;
          end
        end else begin
          state_d = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (key_hit) begin
          pos_d   = idx_q;
          cnt_d   = cnt_q - CW'(1);
          idx_d   = idx_q + CW'(1);
          state_d = ST_DEL_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_POP_RD: state_d = ST_POP_CHK;
      ST_POP_CHK: begin
        ox_d    = rdata_q.x;
        oy_d    = rdata_q.y;
        cnt_d   = cnt_q - CW'(1);
        idx_d   = CW'(1);
        state_d = ST_DEL_RD;
      end
      ST_DEL_RD: begin
        if (idx_q > cnt_q) begin
          if (cmd_q.op == OP_REMOVE) begin
            state_d = ST_RESP;
          end else begin
            hole_d  = cnt_q;
            state_d = ST_INS_RD;
          end
        end else begin
          state_d = ST_DEL_WR;
        end
      end
      ST_DEL_WR: begin
        idx_d   = idx_q + CW'(1);
        state_d = ST_DEL_RD;
      end
      ST_INS_RD: begin
        if (hole_q == '0) begin
          cnt_d   = cnt_q + CW'(1);
          state_d = ST_RESP;
        end else begin
          state_d = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        if (goes_after) begin
          hole_d  = hole_m1;
          state_d = ST_INS_RD;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = ST_RESP;
        end
      end
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory controls, queue pop and result strobe
  always_comb begin
    we        = 1'b0;
    waddr     = hole_q[IW-1:0];
    wdata     = new_entry;
    raddr     = idx_q[IW-1:0];
    cmd_pop_o = 1'b0;
    valid_o   = 1'b0;
    case (state_q)
      ST_IDLE:   cmd_pop_o = cmd_valid_i;
      ST_POP_RD: raddr = '0;
      ST_DEL_WR: begin
        we    = 1'b1;
        waddr = IW'(idx_q - CW'(1));
        wdata = rdata_q;
      end
      ST_INS_RD: begin
        raddr = hole_m1[IW-1:0];
        we    = (hole_q == '0);
      end
      ST_INS_CHK: begin
        we    = 1'b1;
        wdata = goes_after ? rdata_q : new_entry;
      end
      ST_RESP: valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    hole_q   <= hole_d;
    status_q <= status_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
  end

  assign status_o    = status_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign occupancy_o = 7'(cnt_q);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCount) else $error("entry count above capacity");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STATUS_EMPTY) |-> (out_x_o == '0 && out_y_o == '0 && cnt_q == '0))
    else $error("empty result carries data");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STATUS_FULL) |-> (cnt_q == CapCount))
    else $error("full flagged below capacity");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q != ST_IDLE)) else $error("command popped but not started");

endmodule

FILE: tb/sv/kmpq_checker.sv
// checker for the keyed min priority queue: predicts each result beat and compares it
`timescale 1ns / 100ps
module kmpq_checker import kmpq_pkg::*; #(
  parameter int unsigned CAPACITY = KmpqCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         mode_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic [31:0]        priority_req_i,
  input  logic               valid_o,
  input  logic [1:0]         status_o,
  input  logic signed [15:0] out_x_o,
  input  logic signed [15:0] out_y_o,
  input  logic [6:0]         occupancy_o,
  output int                 fail_count,
  output int                 pending,
  output int                 cmd_beats,
  output int                 result_beats,
  output int                 pop_beats,
  output int                 full_beats,
  output int                 empty_beats
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] x;
    logic [15:0] y;
    logic [6:0]  occ;
  } result_t;

  entry_t  queue_model[$];
  result_t expected_results[$];

  initial begin
    fail_count = 0;
    pending = 0;
    cmd_beats = 0;
    result_beats = 0;
    pop_beats = 0;
    full_beats = 0;
    empty_beats = 0;
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  // stable placement: a new entry goes after all entries of priority <= its own
  function automatic void place_entry(input entry_t e);
    int k;
    k = 0;
    while (k < queue_model.size() && queue_model[k].prio <= e.prio) k++;
    queue_model.insert(k, e);
  endfunction

  function automatic result_t apply_command(input logic [1:0] mode, input logic [15:0] x,
                                            input logic [15:0] y, input logic [31:0] prio);
    result_t r;
    int      hit;
    entry_t  e;
    r = '0;
    hit = -1;
    if (mode == MODE_INSERT || mode == MODE_SETPRIO) begin
      foreach (queue_model[i])
        if (hit < 0 && queue_model[i].x == x && queue_model[i].y == y) hit = i;
      if (hit >= 0) begin
        // an entry moving up stays behind equals ahead of it, one moving down stays ahead of equals behind it
        e = queue_model[hit];
        queue_model.delete(hit);
        if (prio < e.prio) begin
          int k;
          k = hit;
          while (k > 0 && queue_model[k-1].prio > prio) k--;
          e.prio = prio;
          queue_model.insert(k, e);
        end else begin
          int k;
          k = hit;
          while (k < queue_model.size() && queue_model[k].prio < prio) k++;
          e.prio = prio;
          queue_model.insert(k, e);
        end
      end else if (mode == MODE_INSERT) begin
        if (queue_model.size() >= CAPACITY) r.status = STATUS_FULL;
        else begin
          e.x = x; e.y = y; e.prio = prio;
          place_entry(e);
        end
      end
    end else if (mode == MODE_REMOVE) begin
      if (queue_model.size() == 0) r.status = STATUS_EMPTY;
      else begin
        e = queue_model.pop_front();
        r.x = e.x;
        r.y = e.y;
      end
    end
    r.occ = 7'(queue_model.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results.push_back(apply_command(mode_i, point_x_i, point_y_i, priority_req_i));
        cmd_beats++;
      end
      if (valid_o) begin
        got = '{status_o, out_x_o, out_y_o, occupancy_o};
        result_beats++;
        if (expected_results.size() == 0) report("result beat with nothing expected");
        else begin
          want = expected_results.pop_front();
          if (got.status != want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.x != want.x) report($sformatf("out_x %h, want %h", got.x, want.x));
          if (got.y != want.y) report($sformatf("out_y %h, want %h", got.y, want.y));
          if (got.occ != want.occ)
            report($sformatf("occupancy %0d, want %0d", got.occ, want.occ));
          if (want.status == STATUS_FULL) full_beats++;
          if (want.status == STATUS_EMPTY) empty_beats++;
          if (want.status == STATUS_OK && (want.x != 0 || want.y != 0)) pop_beats++;
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// top of the keyed min priority queue testbench: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module tb_top;
  import kmpq_pkg::*;

  localparam int RandomBeats = 1750;
  localparam int IdleLimit   = 4000;  // far above the longest command

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         mode_i;
  logic signed [15:0] point_x_i;
  logic signed [15:0] point_y_i;
  logic [31:0]        priority_req_i;
  logic               valid_o;
  logic [1:0]         status_o;
  logic signed [15:0] out_x_o;
  logic signed [15:0] out_y_o;
  logic [6:0]         occupancy_o;

  int fail_count, pending, cmd_beats, result_beats, pop_beats, full_beats, empty_beats;
  int idle_cycles;
  int prev_cmds, prev_results;

  // small pool of points so updates and set-priority hits are frequent
  logic [15:0] pool_x[16];
  logic [15:0] pool_y[16];

  keyed_min_priority_queue DUT (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .point_x_i, .point_y_i, .priority_req_i,
    .valid_o, .status_o, .out_x_o, .out_y_o, .occupancy_o
  );

  kmpq_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .point_x_i, .point_y_i, .priority_req_i,
    .valid_o, .status_o, .out_x_o, .out_y_o, .occupancy_o,
    .fail_count, .pending, .cmd_beats, .result_beats, .pop_beats, .full_beats, .empty_beats
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: ends the run after too many cycles with no beat in either direction
  initial begin
    idle_cycles = 0;
    prev_cmds = 0;
    prev_results = 0;
    forever begin
      @(posedge clk_i);
      #0.1;
      if (cmd_beats != prev_cmds || result_beats != prev_results) idle_cycles = 0;
      else idle_cycles++;
      prev_cmds = cmd_beats;
      prev_results = result_beats;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("keyed_min_priority_queue regression: fail");
        $finish;
      end
    end
  end

  // one command beat: drive at the falling edge, hold until accepted
  task automatic send_cmd(input logic [1:0] mode, input logic [15:0] x, input logic [15:0] y,
                          input logic [31:0] prio);
    mode_i <= mode;
    point_x_i <= x;
    point_y_i <= y;
    priority_req_i <= prio;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drop_start();
    start <= 1'b0;
  endtask

  function automatic logic [31:0] rand_prio();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 3);                 // heavy ties
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return {16'($urandom_range(0, 7)), 16'h0000}; // whole numbers in 16.16
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int burst, gap, sel, fill;
    logic [1:0] m;
    start = 1'b0;
    mode_i = MODE_INSERT;
    point_x_i = '0;
    point_y_i = '0;
    priority_req_i = '0;
    rst_ni = 1'b0;
    foreach (pool_x[i]) begin
      pool_x[i] = 16'($urandom());
      pool_y[i] = 16'($urandom());
    end
    pool_x[0] = 16'h8000; pool_y[0] = 16'h7FFF;
    pool_x[1] = 16'h7FFF; pool_y[1] = 16'h8000;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: remove when empty, extremes, update up and down, ties, absent set, unused mode
    send_cmd(MODE_REMOVE, 16'h1234, 16'h5678, 32'h0);
    send_cmd(MODE_SETPRIO, 16'h0001, 16'h0001, 32'h5);
    send_cmd(MODE_INSERT, 16'h8000, 16'h8000, 32'hFFFF_FFFF);
    send_cmd(MODE_INSERT, 16'h7FFF, 16'h7FFF, 32'h0);
    send_cmd(MODE_INSERT, 16'hFFFF, 16'h0000, 32'h0001_0000);
    send_cmd(MODE_INSERT, 16'h0000, 16'hFFFF, 32'h0001_0000);
    send_cmd(MODE_INSERT, 16'h0001, 16'h0002, 32'h0001_0000);
    send_cmd(MODE_INSERT, 16'h7FFF, 16'h7FFF, 32'h0001_0000);
    send_cmd(MODE_SETPRIO, 16'h8000, 16'h8000, 32'h0);
    send_cmd(MODE_SETPRIO, 16'h0001, 16'h0002, 32'h8000_0000);
    send_cmd(OP_NOP, 16'hAAAA, 16'h5555, 32'h5555_AAAA);
    repeat (6) send_cmd(MODE_REMOVE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    // fill to capacity, then full insert, update while full, set while full
    for (int i = 0; i < KmpqCapacity; i++)
      send_cmd(MODE_INSERT, 16'(i), ~16'(i), $urandom_range(0, 9));
    send_cmd(MODE_INSERT, 16'h4000, 16'h4000, 32'h1);
    send_cmd(MODE_INSERT, 16'd3, ~16'd3, 32'h0);
    send_cmd(MODE_SETPRIO, 16'd5, ~16'd5, 32'hFFFF_FFFF);
    for (int i = 0; i < KmpqCapacity; i++) send_cmd(MODE_REMOVE, '0, '0, '0);
    drop_start();

    // random: bursts with gaps; mostly pool points, each phase picks a fill, balanced or drain bias at random
    fill = 0;
    for (int n = 0; n < RandomBeats; ) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && n < RandomBeats; b++, n++) begin
        if (n % 300 == 0) fill = $urandom_range(0, 2);
        sel = $urandom_range(0, 99);
        if (sel < 2) m = OP_NOP;
        else if (sel < (fill == 0 ? 60 : fill == 1 ? 35 : 20)) m = MODE_INSERT;
        else if (sel < 75) m = MODE_SETPRIO;
        else m = MODE_REMOVE;
        if ($urandom_range(0, 3) == 0)
          send_cmd(m, 16'($urandom()), 16'($urandom()), rand_prio());
        else begin
          sel = $urandom_range(0, 15);
          send_cmd(m, pool_x[sel], pool_y[sel], rand_prio());
        end
      end
      drop_start();
      if ($urandom_range(0, 2) != 0) begin
        gap = $urandom_range(1, 12);
        repeat (gap) @(negedge clk_i);
      end
    end
    drop_start();

    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);

    $display("covered %0d commands, %0d results: %0d pops, %0d full, %0d empty",
             cmd_beats, result_beats, pop_beats, full_beats, empty_beats);
    if (fail_count == 0 && pending == 0) begin
      $display("keyed_min_priority_queue regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("keyed_min_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
